>>> rtl/plsp_pkg.sv
// Package: shared widths, op codes and constants of the setpoint profile core.
package plsp_pkg;
    localparam int LEVEL_W = 16;
    localparam int MS_W    = 20;
    localparam int DUR_W   = 30;
    localparam int TIME_W  = 40;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [9:0] US_PER_MS = 10'd1000;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [DUR_W-1:0]   dur_t;
endpackage

>>> rtl/plsp_cell.sv
// One segment cell: holds one table entry and passes the search beat to its neighbor.
module plsp_cell #(
    parameter int IDX     = 0,
    parameter int IDX_W   = 5,
    parameter int CNT_W   = 6,
    parameter int START_W = 35,
    parameter int END_W   = 36,
    parameter int CMP_W   = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_idx,
    input  logic [START_W-1:0]   wr_start,
    input  logic [END_W-1:0]     wr_end,
    input  plsp_pkg::dur_t       wr_dur,
    input  plsp_pkg::level_t     wr_from,
    input  plsp_pkg::level_t     wr_to,
    input  logic [CNT_W-1:0]     count,
    input  logic [CMP_W-1:0]     t,
    input  logic                 in_hit,
    input  logic [START_W-1:0]   in_start,
    input  plsp_pkg::dur_t       in_dur,
    input  plsp_pkg::level_t     in_from,
    input  plsp_pkg::level_t     in_to,
    output logic                 out_hit,
    output logic [START_W-1:0]   out_start,
    output plsp_pkg::dur_t       out_dur,
    output plsp_pkg::level_t     out_from,
    output plsp_pkg::level_t     out_to
);
    import plsp_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

    logic [START_W-1:0] start_reg;
    logic [END_W-1:0]   end_reg;
    dur_t               dur_reg;
    level_t             from_reg;
    level_t             to_reg;
    logic               hit_reg;
    logic [START_W-1:0] pstart_reg;
    dur_t               pdur_reg;
    level_t             pfrom_reg;
    level_t             pto_reg;
    logic               match;

    // live entry whose end is not earlier than t
    assign match = (MY_CNT < count) && (t <= CMP_W'(end_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == MY_IDX))
        begin
            start_reg <= wr_start;
            end_reg   <= wr_end;
            dur_reg   <= wr_dur;
            from_reg  <= wr_from;
            to_reg    <= wr_to;
        end
        if (in_hit)
        begin
            pstart_reg <= in_start;
            pdur_reg   <= in_dur;
            pfrom_reg  <= in_from;
            pto_reg    <= in_to;
        end
        else
        begin
            pstart_reg <= start_reg;
            pdur_reg   <= dur_reg;
            pfrom_reg  <= from_reg;
            pto_reg    <= to_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= in_hit | match;
        end
    end

    assign out_hit   = hit_reg;
    assign out_start = pstart_reg;
    assign out_dur   = pdur_reg;
    assign out_from  = pfrom_reg;
    assign out_to    = pto_reg;
endmodule

>>> rtl/plsp_div.sv
// Restoring divider, one quotient bit per cycle.
module plsp_div #(
    parameter int NUM_W = 46,
    parameter int DEN_W = 30
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);
    import plsp_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam logic [STEP_W-1:0] LAST = STEP_W'(NUM_W - 1);

    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [NUM_W-1:0]  q_reg;
    logic [NUM_W-1:0]  q_next;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic              done_reg;
    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;

    always_comb
    begin
        shifted = {rem_reg, q_reg[NUM_W-1]};
        diff    = shifted - {1'b0, den_reg};
        if (!diff[DEN_W])
        begin
            rem_next = diff[DEN_W-1:0];
            q_next   = {q_reg[NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[DEN_W-1:0];
            q_next   = {q_reg[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            q_reg   <= num;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo  = q_reg;
    assign done = done_reg;
endmodule

>>> rtl/piecewise_linear_setpoint_profile_core.sv
// Top level: piecewise-linear setpoint profile core built on a row of segment cells.
//
// Usage: pulse start with op and the operand fields while busy is low; the beat
// is taken at that edge. Each command returns exactly one result beat on
// accepted/found/pwm, marked by a one-cycle done strobe. The receiver cannot
// stall; a result is simply presented for one cycle.
//   op clear  : empties the table; result the next cycle (accepted = 1).
//   op append : stores one segment in the next free cell; result the next
//               cycle, accepted = 0 when the table is full.
//   op query  : a search beat walks the row of MAX_SEGMENTS cells, one cell per
//               cycle, picking the first segment whose end is not before the
//               time. Hold, zero-length and miss results come once the beat
//               has left the last cell; a ramp then passes the multiply state
//               and a serial divide before its result.
//   other op  : all-zero result the next cycle.
// busy is high while a query runs; one command is in flight at a time.
// Reset empties the table; stored segment contents are not cleared.
module piecewise_linear_setpoint_profile_core #(
    parameter int MAX_SEGMENTS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [plsp_pkg::OP_W-1:0]     op,
    input  logic [plsp_pkg::LEVEL_W-1:0]  from_pwm,
    input  logic [plsp_pkg::LEVEL_W-1:0]  end_pwm,
    input  logic [plsp_pkg::MS_W-1:0]     duration_ms,
    input  logic [plsp_pkg::TIME_W-1:0]   query_time_us,
    output logic                          done,
    output logic                          accepted,
    output logic                          found,
    output logic [plsp_pkg::LEVEL_W-1:0]  pwm
);
    import plsp_pkg::*;

    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int START_W = DUR_W + $clog2(MAX_SEGMENTS);
    localparam int END_W   = START_W + 1;
    localparam int CMP_W   = (END_W > TIME_W) ? END_W : TIME_W;
    localparam int NUM_W   = DUR_W + LEVEL_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_MUL    = 2'd2;
    localparam logic [1:0] ST_DIV    = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [END_W-1:0]  tail_reg, tail_next;
    logic [CMP_W-1:0]  t_reg, t_next;
    level_t            from_reg, from_next;
    level_t            mag_reg, mag_next;
    logic              neg_reg, neg_next;
    dur_t              dur_reg, dur_next;
    dur_t              elapsed_reg, elapsed_next;
    logic              done_reg, done_next;
    logic              acc_reg, acc_next;
    logic              found_reg, found_next;
    level_t            pwm_reg, pwm_next;

    logic              wr_en;
    dur_t              dur_us;
    logic [END_W-1:0]  new_end;
    logic [CMP_W-1:0]  since;
    logic              div_go;
    logic [NUM_W-1:0]  div_num;
    logic [NUM_W-1:0]  div_quo;
    logic              div_done;

    // search beat wires along the cell row
    logic               hit_w   [0:MAX_SEGMENTS];
    logic [START_W-1:0] start_w [0:MAX_SEGMENTS];
    dur_t               dur_w   [0:MAX_SEGMENTS];
    level_t             from_w  [0:MAX_SEGMENTS];
    level_t             to_w    [0:MAX_SEGMENTS];

    assign hit_w[0]   = 1'b0;
    assign start_w[0] = '0;
    assign dur_w[0]   = '0;
    assign from_w[0]  = '0;
    assign to_w[0]    = '0;

    // ms -> us, then lay the segment after the current tail
    assign dur_us  = DUR_W'({10'd0, duration_ms} * {20'd0, US_PER_MS});
    assign new_end = tail_reg + END_W'(dur_us);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SEGMENTS; gi++)
        begin : g_cell
            plsp_cell #(
                .IDX     (gi),
                .IDX_W   (IDX_W),
                .CNT_W   (CNT_W),
                .START_W (START_W),
                .END_W   (END_W),
                .CMP_W   (CMP_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr_en     (wr_en),
                .wr_idx    (count_reg[IDX_W-1:0]),
                .wr_start  (tail_reg[START_W-1:0]),
                .wr_end    (new_end),
                .wr_dur    (dur_us),
                .wr_from   (from_pwm),
                .wr_to     (end_pwm),
                .count     (count_reg),
                .t         (t_reg),
                .in_hit    (hit_w[gi]),
                .in_start  (start_w[gi]),
                .in_dur    (dur_w[gi]),
                .in_from   (from_w[gi]),
                .in_to     (to_w[gi]),
                .out_hit   (hit_w[gi+1]),
                .out_start (start_w[gi+1]),
                .out_dur   (dur_w[gi+1]),
                .out_from  (from_w[gi+1]),
                .out_to    (to_w[gi+1])
            );
        end
    endgenerate

    // elapsed time into the found segment, before clamping
    assign since   = t_reg - CMP_W'(start_w[MAX_SEGMENTS]);
    assign div_num = NUM_W'(elapsed_reg) * NUM_W'(mag_reg);

    plsp_div #(
        .NUM_W (NUM_W),
        .DEN_W (DUR_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (div_num),
        .den   (dur_reg),
        .quo   (div_quo),
        .done  (div_done)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        cnt_next     = cnt_reg;
        tail_next    = tail_reg;
        t_next       = t_reg;
        from_next    = from_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        dur_next     = dur_reg;
        elapsed_next = elapsed_reg;
        done_next    = 1'b0;
        acc_next     = 1'b0;
        found_next   = 1'b0;
        pwm_next     = '0;
        wr_en        = 1'b0;
        div_go       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            tail_next  = '0;
                            done_next  = 1'b1;
                            acc_next   = 1'b1;
                        end
                        OP_APPEND:
                        begin
                            done_next = 1'b1;
                            if (count_reg < MAX_CNT)
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                tail_next  = new_end;
                                acc_next   = 1'b1;
                            end
                        end
                        OP_QUERY:
                        begin
                            t_next     = CMP_W'(query_time_us);
                            cnt_next   = '0;
                            state_next = ST_SEARCH;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (cnt_reg == MAX_CNT)
                begin
                    from_next = from_w[MAX_SEGMENTS];
                    dur_next  = dur_w[MAX_SEGMENTS];
                    neg_next  = to_w[MAX_SEGMENTS] < from_w[MAX_SEGMENTS];
                    mag_next  = neg_next ? (from_w[MAX_SEGMENTS] - to_w[MAX_SEGMENTS])
                                         : (to_w[MAX_SEGMENTS] - from_w[MAX_SEGMENTS]);
                    if (t_reg <= CMP_W'(start_w[MAX_SEGMENTS]))
                    begin
                        elapsed_next = '0;
                    end
                    else if (since > CMP_W'(dur_w[MAX_SEGMENTS]))
                    begin
                        elapsed_next = dur_w[MAX_SEGMENTS];
                    end
                    else
                    begin
                        elapsed_next = since[DUR_W-1:0];
                    end
                    priority if (!hit_w[MAX_SEGMENTS])
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if ((from_w[MAX_SEGMENTS] == to_w[MAX_SEGMENTS])
                             || (dur_w[MAX_SEGMENTS] == '0))
                    begin
                        done_next  = 1'b1;
                        found_next = 1'b1;
                        pwm_next   = from_w[MAX_SEGMENTS];
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                div_go     = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    pwm_next   = neg_reg ? (from_reg - div_quo[LEVEL_W-1:0])
                                         : (from_reg + div_quo[LEVEL_W-1:0]);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        t_reg       <= t_next;
        from_reg    <= from_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        dur_reg     <= dur_next;
        elapsed_reg <= elapsed_next;
        acc_reg     <= acc_next;
        found_reg   <= found_next;
        pwm_reg     <= pwm_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            cnt_reg   <= '0;
            tail_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cnt_reg   <= cnt_next;
            tail_reg  <= tail_next;
            done_reg  <= done_next;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign accepted = acc_reg;
    assign found    = found_reg;
    assign pwm      = pwm_reg;

    // a result beat never reports both an accepted command and a hit
    a_acc_found: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(accepted && found))
        else $error("accepted and found both set");

    // a miss always reads as level zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (pwm == '0))
        else $error("pwm nonzero on miss");

    // the table never holds more than its capacity
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("segment count overflow");

    // a query beat makes the core busy on the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_QUERY)) |=> busy)
        else $error("query not started");
endmodule
